[sv/dpec_pkg.sv]
// Package for the disk pair elastic collision pipeline.
// Holds field widths, the Q2.14 scale constants and the side-band struct.
// No dependencies.
package dpec_pkg;

   localparam int POS_W      = 24;
   localparam int VEL_W      = 16;
   localparam int RAD_W      = 10;
   localparam int MASS_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int SCALE_FRAC = 14;
   // Quotient bits of each correction term; the term never reaches 2^19.
   localparam int QUOT_W     = 20;
   localparam int LANES      = 4;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h8000;

   typedef logic signed [VEL_W-1:0] vel_type;

   typedef struct packed {
      vel_type u1;
      vel_type w1;
      vel_type u2;
      vel_type w2;
   } vel4_type;

   // Flags and the input velocities that ride along with an item through the divider.
   typedef struct packed {
      logic             appr;
      logic             coll;
      logic             degen;
      logic             msum_zero;
      logic [LANES-1:0] neg;
      vel4_type         vel;
   } side_type;

endpackage

[sv/disk_pair_elastic_collision.sv]
// Top level of the disk pair elastic collision pipeline.
// Depends on dpec_pkg for widths, the scale reset value and the side-band struct.
//
//   channel | ports            | direction | beat
//   --------+------------------+-----------+-----------------------------------
//   req     | req_valid/stall  | in        | two disks: position, velocity,
//           |                  |           | radius, mass
//   rsp     | rsp_valid/stall  | out       | flags and four new velocities
//   csr     | csr_wr_en/data   | in        | momentum_scale, Q2.14
//
// One beat enters per cycle while the pipeline is not held; new beats enter
// before earlier ones leave. The four restoring dividers give one quotient
// bit per stage. The whole pipeline moves together and holds only while a
// result sits in the output register and rsp_stall is high. Synchronous
// reset clears the valid bits and loads momentum_scale with 2.0.
module disk_pair_elastic_collision
   import dpec_pkg::*;
#(
   parameter int POS_FRAC_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_first_pos_x,
   input  logic signed [POS_W-1:0]  req_first_pos_y,
   input  logic signed [VEL_W-1:0]  req_first_vel_x,
   input  logic signed [VEL_W-1:0]  req_first_vel_y,
   input  logic [RAD_W-1:0]         req_first_radius,
   input  logic [MASS_W-1:0]        req_first_mass,
   input  logic signed [POS_W-1:0]  req_second_pos_x,
   input  logic signed [POS_W-1:0]  req_second_pos_y,
   input  logic signed [VEL_W-1:0]  req_second_vel_x,
   input  logic signed [VEL_W-1:0]  req_second_vel_y,
   input  logic [RAD_W-1:0]         req_second_radius,
   input  logic [MASS_W-1:0]        req_second_mass,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_approaching,
   output logic                     rsp_collides,
   output logic signed [VEL_W-1:0]  rsp_first_new_vel_x,
   output logic signed [VEL_W-1:0]  rsp_first_new_vel_y,
   output logic signed [VEL_W-1:0]  rsp_second_new_vel_x,
   output logic signed [VEL_W-1:0]  rsp_second_new_vel_y,
   output logic                     rsp_degenerate,
   output logic                     rsp_saturated,
   input  logic                     csr_wr_en,
   input  logic [SCALE_W-1:0]       csr_wr_data
);

   // Widths. A colliding pair has |d| at most the radius sum, which bounds
   // every magnitude used by the impulse path.
   localparam int D_W     = POS_W + 1;
   localparam int DV_W    = VEL_W + 1;
   localparam int PROD_W  = D_W + DV_W;
   localparam int DOT_W   = PROD_W + 1;
   localparam int SQ_W    = 2 * D_W;
   localparam int DSQ_W   = SQ_W + 1;
   localparam int RS_W    = RAD_W + 1 + POS_FRAC_BITS;
   localparam int RS2_W   = 2 * RS_W;
   localparam int CMP_W   = (RS2_W > DSQ_W) ? RS2_W : DSQ_W;
   localparam int DC_W    = (RS_W < D_W) ? RS_W : D_W;
   localparam int DOTM_W  = DC_W + DV_W + 1;
   localparam int DIST_W  = 2 * DC_W + 1;
   localparam int P_W     = DOTM_W + DC_W;
   localparam int KM_W    = SCALE_W + MASS_W;
   localparam int MS_W    = MASS_W + 1;
   localparam int DM_W    = MS_W + DIST_W;
   localparam int DEN_W   = DM_W + SCALE_FRAC;
   localparam int NUM_W   = DEN_W + QUOT_W;
   localparam int RES_W   = VEL_W + 6;

   logic en;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   // The pipeline advances unless the output register is held.
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   always_comb begin
      scale_in = scale_ff;
      if (csr_wr_en) begin
         scale_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // Stage 1: differences of position and velocity, radius sum.
   logic                    v1_ff;
   logic signed [D_W-1:0]   dx1_ff, dy1_ff;
   logic signed [DV_W-1:0]  dvx1_ff, dvy1_ff;
   logic [RAD_W:0]          rsum1_ff;
   logic [MASS_W-1:0]       m1_1_ff, m2_1_ff;
   vel4_type                vel1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= {req_first_pos_x[POS_W-1], req_first_pos_x}
                   - {req_second_pos_x[POS_W-1], req_second_pos_x};
         dy1_ff   <= {req_first_pos_y[POS_W-1], req_first_pos_y}
                   - {req_second_pos_y[POS_W-1], req_second_pos_y};
         dvx1_ff  <= {req_first_vel_x[VEL_W-1], req_first_vel_x}
                   - {req_second_vel_x[VEL_W-1], req_second_vel_x};
         dvy1_ff  <= {req_first_vel_y[VEL_W-1], req_first_vel_y}
                   - {req_second_vel_y[VEL_W-1], req_second_vel_y};
         rsum1_ff <= {1'b0, req_first_radius} + {1'b0, req_second_radius};
         m1_1_ff  <= req_first_mass;
         m2_1_ff  <= req_second_mass;
         vel1_ff  <= '{u1: req_first_vel_x, w1: req_first_vel_y,
                       u2: req_second_vel_x, w2: req_second_vel_y};
      end
   end

   // Stage 2: the dot product terms, squares and scaled masses.
   logic [D_W-1:0] adx1, ady1;
   logic [RS_W-1:0] rs1;
   assign adx1 = dx1_ff[D_W-1] ? D_W'(-dx1_ff) : D_W'(dx1_ff);
   assign ady1 = dy1_ff[D_W-1] ? D_W'(-dy1_ff) : D_W'(dy1_ff);
   assign rs1  = {rsum1_ff, {POS_FRAC_BITS{1'b0}}};

   logic                      v2_ff;
   logic signed [PROD_W-1:0]  px2_ff, py2_ff;
   logic [SQ_W-1:0]           sqx2_ff, sqy2_ff;
   logic [RS2_W-1:0]          rs2_2_ff;
   logic [MS_W-1:0]           msum2_ff;
   logic [KM_W-1:0]           km1_2_ff, km2_2_ff;
   logic                      degen2_ff, sdx2_ff, sdy2_ff;
   logic [DC_W-1:0]           adx2_ff, ady2_ff;
   vel4_type                  vel2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px2_ff    <= PROD_W'(dvx1_ff) * PROD_W'(dx1_ff);
         py2_ff    <= PROD_W'(dvy1_ff) * PROD_W'(dy1_ff);
         sqx2_ff   <= SQ_W'(adx1) * SQ_W'(adx1);
         sqy2_ff   <= SQ_W'(ady1) * SQ_W'(ady1);
         rs2_2_ff  <= RS2_W'(rs1) * RS2_W'(rs1);
         msum2_ff  <= {1'b0, m1_1_ff} + {1'b0, m2_1_ff};
         km1_2_ff  <= KM_W'(scale_ff) * KM_W'(m1_1_ff);
         km2_2_ff  <= KM_W'(scale_ff) * KM_W'(m2_1_ff);
         degen2_ff <= (dx1_ff == '0) && (dy1_ff == '0);
         sdx2_ff   <= dx1_ff[D_W-1];
         sdy2_ff   <= dy1_ff[D_W-1];
         adx2_ff   <= adx1[DC_W-1:0];
         ady2_ff   <= ady1[DC_W-1:0];
         vel2_ff   <= vel1_ff;
      end
   end

   // Stage 3: dot product, squared distance and the decision flags.
   logic signed [DOT_W-1:0] dot2;
   logic [DOT_W-1:0]        dotm2;
   logic [DSQ_W-1:0]        dist2;
   logic                    appr2;
   assign dot2  = {px2_ff[PROD_W-1], px2_ff} + {py2_ff[PROD_W-1], py2_ff};
   assign dotm2 = dot2[DOT_W-1] ? DOT_W'(-dot2) : DOT_W'(dot2);
   assign dist2 = {1'b0, sqx2_ff} + {1'b0, sqy2_ff};
   assign appr2 = dot2[DOT_W-1];

   logic                v3_ff;
   logic                dneg3_ff, appr3_ff, coll3_ff, degen3_ff, msz3_ff;
   logic                sdx3_ff, sdy3_ff;
   logic [DOTM_W-1:0]   dotm3_ff;
   logic [DIST_W-1:0]   dist3_ff;
   logic [MS_W-1:0]     msum3_ff;
   logic [KM_W-1:0]     km1_3_ff, km2_3_ff;
   logic [DC_W-1:0]     adx3_ff, ady3_ff;
   vel4_type            vel3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dneg3_ff  <= appr2;
         appr3_ff  <= appr2;
         coll3_ff  <= appr2 && (CMP_W'(dist2) <= CMP_W'(rs2_2_ff));
         degen3_ff <= degen2_ff;
         msz3_ff   <= (msum2_ff == '0);
         sdx3_ff   <= sdx2_ff;
         sdy3_ff   <= sdy2_ff;
         dotm3_ff  <= dotm2[DOTM_W-1:0];
         dist3_ff  <= dist2[DIST_W-1:0];
         msum3_ff  <= msum2_ff;
         km1_3_ff  <= km1_2_ff;
         km2_3_ff  <= km2_2_ff;
         adx3_ff   <= adx2_ff;
         ady3_ff   <= ady2_ff;
         vel3_ff   <= vel2_ff;
      end
   end

   // Stage 4: |dot| times each component, and the mass-weighted distance.
   logic              v4_ff;
   logic [P_W-1:0]    px4_ff, py4_ff;
   logic [DM_W-1:0]   dm4_ff;
   logic [KM_W-1:0]   km1_4_ff, km2_4_ff;
   side_type          side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px4_ff   <= P_W'(dotm3_ff) * P_W'(adx3_ff);
         py4_ff   <= P_W'(dotm3_ff) * P_W'(ady3_ff);
         dm4_ff   <= DM_W'(msum3_ff) * DM_W'(dist3_ff);
         km1_4_ff <= km1_3_ff;
         km2_4_ff <= km2_3_ff;
         // Lanes: first x, first y, second x, second y.
         side4_ff <= '{appr: appr3_ff, coll: coll3_ff, degen: degen3_ff,
                       msum_zero: msz3_ff,
                       neg: {dneg3_ff ^ sdy3_ff, dneg3_ff ^ sdx3_ff,
                             dneg3_ff ^ sdy3_ff, dneg3_ff ^ sdx3_ff},
                       vel: vel3_ff};
      end
   end

   // Stage 5: scale times mass times the product, cut into two partial
   // products per lane so no multiplier exceeds 32 bits on a side.
   logic [P_W-1:0]  lane_p  [LANES];
   logic [KM_W-1:0] lane_km [LANES];
   assign lane_p[0]  = px4_ff;
   assign lane_p[1]  = py4_ff;
   assign lane_p[2]  = px4_ff;
   assign lane_p[3]  = py4_ff;
   assign lane_km[0] = km2_4_ff;
   assign lane_km[1] = km2_4_ff;
   assign lane_km[2] = km1_4_ff;
   assign lane_km[3] = km1_4_ff;

   logic               v5_ff;
   logic [63:0]        lo5_ff [LANES];
   logic [P_W-1:0]     hi5_ff [LANES];
   logic [DM_W-1:0]    dm5_ff;
   side_type           side5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            lo5_ff[l] <= 64'(lane_km[l]) * 64'(lane_p[l][31:0]);
            hi5_ff[l] <= P_W'(lane_km[l]) * P_W'(lane_p[l][P_W-1:32]);
         end
         dm5_ff   <= dm4_ff;
         side5_ff <= side4_ff;
      end
   end

   // Stage 6: numerator with half the divisor added for rounding. Then the
   // dividers, one quotient bit per stage.
   logic [NUM_W-1:0] num5 [LANES];
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num5[l] = NUM_W'(lo5_ff[l]) + (NUM_W'(hi5_ff[l]) << 32)
                 + (NUM_W'(dm5_ff) << (SCALE_FRAC - 1));
      end
   end

   logic             dv_ff   [QUOT_W+1];
   logic [DEN_W-1:0] den_ff  [QUOT_W+1];
   side_type         side_ff [QUOT_W+1];
   logic [DEN_W-1:0] rem_ff  [QUOT_W+1][LANES];
   logic [QUOT_W-1:0] low_ff [QUOT_W+1][LANES];
   logic [QUOT_W-1:0] quot_ff[QUOT_W+1][LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff[0]  <= {dm5_ff, {SCALE_FRAC{1'b0}}};
         side_ff[0] <= side5_ff;
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l]  <= num5[l][NUM_W-1:QUOT_W];
            low_ff[0][l]  <= num5[l][QUOT_W-1:0];
            quot_ff[0][l] <= '0;
         end
      end
   end

   for (genvar k = 1; k <= QUOT_W; k++) begin : g_div
      logic [DEN_W:0]   trial  [LANES];
      logic             take   [LANES];
      logic [DEN_W-1:0] rem_in [LANES];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]  = {rem_ff[k-1][l], low_ff[k-1][l][QUOT_W-1]};
            take[l]   = trial[l] >= {1'b0, den_ff[k-1]};
            rem_in[l] = take[l] ? DEN_W'(trial[l] - {1'b0, den_ff[k-1]})
                                : trial[l][DEN_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
            for (int l = 0; l < LANES; l++) begin
               rem_ff[k][l]  <= rem_in[l];
               low_ff[k][l]  <= {low_ff[k-1][l][QUOT_W-2:0], 1'b0};
               quot_ff[k][l] <= {quot_ff[k-1][l][QUOT_W-2:0], take[l]};
            end
         end
      end
   end

   // Final stage: apply signed corrections, clamp and load the output.
   side_type side_q;
   logic signed [RES_W-1:0] corr [LANES];
   logic signed [RES_W-1:0] base [LANES];
   logic signed [RES_W-1:0] res  [LANES];
   logic [VEL_W-1:0]        clip [LANES];
   logic [LANES-1:0]        over;
   logic                    apply;

   assign side_q = side_ff[QUOT_W];
   assign apply  = side_q.coll && !side_q.msum_zero;
   assign base[0] = RES_W'(side_q.vel.u1);
   assign base[1] = RES_W'(side_q.vel.w1);
   assign base[2] = RES_W'(side_q.vel.u2);
   assign base[3] = RES_W'(side_q.vel.w2);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         corr[l] = side_q.neg[l] ? -RES_W'(quot_ff[QUOT_W][l])
                                 :  RES_W'(quot_ff[QUOT_W][l]);
         // The first disk takes the correction away, the second adds it.
         res[l]  = (l < 2) ? base[l] - corr[l] : base[l] + corr[l];
         if (!apply) begin
            res[l] = base[l];
         end
         over[l] = 1'b0;
         clip[l] = res[l][VEL_W-1:0];
         if (res[l] > RES_W'(32767)) begin
            clip[l] = 16'h7FFF;
            over[l] = 1'b1;
         end else if (res[l] < -RES_W'(32768)) begin
            clip[l] = 16'h8000;
            over[l] = 1'b1;
         end
      end
   end

   logic rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_approaching      <= side_q.appr;
         rsp_collides         <= side_q.coll;
         rsp_degenerate       <= side_q.degen;
         rsp_first_new_vel_x  <= clip[0];
         rsp_first_new_vel_y  <= clip[1];
         rsp_second_new_vel_x <= clip[2];
         rsp_second_new_vel_y <= clip[3];
         rsp_saturated        <= |over;
      end
   end

endmodule

[bench/tb_disk_pair_elastic_collision.sv]
// Self-checking testbench for disk_pair_elastic_collision.
// Depends on dpec_pkg and the block's RTL; a scoreboard class predicts every beat.
module tb_disk_pair_elastic_collision
   import dpec_pkg::*;
();

   localparam int POS_FRAC  = 8;
   localparam int DRAIN     = 40;       // well past the depth of the pipeline
   localparam int MAX_CYCLE = 1000000;

   typedef struct {
      logic signed [POS_W-1:0] x1, y1, x2, y2;
      logic signed [VEL_W-1:0] u1, w1, u2, w2;
      logic [RAD_W-1:0]        r1, r2;
      logic [MASS_W-1:0]       m1, m2;
   } pair_type;

   typedef struct {
      logic appr, coll, degen, sat;
      logic signed [VEL_W-1:0] n1x, n1y, n2x, n2y;
   } outcome_type;

   // The scoreboard holds its own copy of momentum_scale and a queue of the
   // outcomes that the accepted beats should produce, oldest first.
   class collision_scoreboard;
      logic [SCALE_W-1:0] scale;
      outcome_type        pending[$];
      int                 errors;
      int                 checked;
      int                 collisions;
      int                 saturations;

      function new();
         scale = SCALE_RESET;
         errors = 0;
         checked = 0;
         collisions = 0;
         saturations = 0;
      endfunction

      static function logic [63:0] magnitude(longint v);
         return (v < 0) ? -v : v;
      endfunction

      // One correction term, K*m*dot*dcomp / (M*|d|^2*2^14), rounded to the
      // nearest integer with ties away from zero.
      static function longint impulse(longint dot, longint dcomp, logic [31:0] km,
                                      logic [191:0] den);
         logic [191:0] num;
         logic [191:0] q;
         num = 192'(magnitude(dot)) * 192'(magnitude(dcomp)) * 192'(km);
         q = (192'(2) * num + den) / (192'(2) * den);
         if (q > (192'd1 << 40))
            q = 192'd1 << 40;
         return ((dot < 0) != (dcomp < 0)) ? -longint'(q) : longint'(q);
      endfunction

      static function logic signed [VEL_W-1:0] clamp(longint v, ref logic sat);
         if (v > 32767) begin
            sat = 1'b1;
            return 16'sh7fff;
         end
         if (v < -32768) begin
            sat = 1'b1;
            return 16'sh8000;
         end
         return v[VEL_W-1:0];
      endfunction

      task note_pair(pair_type p);
         outcome_type o;
         longint dx, dy, dot, n1x, n1y, n2x, n2y;
         logic [63:0] dist2, rsum, msum;
         logic [191:0] den;
         dx = longint'(p.x1) - longint'(p.x2);
         dy = longint'(p.y1) - longint'(p.y2);
         dot = (longint'(p.u1) - longint'(p.u2)) * dx + (longint'(p.w1) - longint'(p.w2)) * dy;
         dist2 = magnitude(dx) * magnitude(dx) + magnitude(dy) * magnitude(dy);
         rsum = (64'(p.r1) + 64'(p.r2)) << POS_FRAC;
         msum = 64'(p.m1) + 64'(p.m2);
         o.appr = dot < 0;
         o.coll = o.appr && (dist2 <= rsum * rsum);
         o.degen = (dx == 0) && (dy == 0);
         o.sat = 1'b0;
         n1x = longint'(p.u1);
         n1y = longint'(p.w1);
         n2x = longint'(p.u2);
         n2y = longint'(p.w2);
         if (o.coll && msum != 0) begin
            den = (192'(msum) * 192'(dist2)) << SCALE_FRAC;
            n1x = n1x - impulse(dot, dx, 32'(scale) * 32'(p.m2), den);
            n1y = n1y - impulse(dot, dy, 32'(scale) * 32'(p.m2), den);
            n2x = n2x + impulse(dot, dx, 32'(scale) * 32'(p.m1), den);
            n2y = n2y + impulse(dot, dy, 32'(scale) * 32'(p.m1), den);
         end
         o.n1x = clamp(n1x, o.sat);
         o.n1y = clamp(n1y, o.sat);
         o.n2x = clamp(n2x, o.sat);
         o.n2y = clamp(n2y, o.sat);
         pending.push_back(o);
      endtask

      task report(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      endtask

      task check_beat(outcome_type g);
         outcome_type e;
         if (pending.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.coll) collisions++;
         if (e.sat) saturations++;
         if (g.appr !== e.appr) report("approaching", g.appr, e.appr);
         if (g.coll !== e.coll) report("collides", g.coll, e.coll);
         if (g.degen !== e.degen) report("degenerate", g.degen, e.degen);
         if (g.sat !== e.sat) report("saturated", g.sat, e.sat);
         if (g.n1x !== e.n1x) report("first_new_vel_x", 32'(g.n1x), 32'(e.n1x));
         if (g.n1y !== e.n1y) report("first_new_vel_y", 32'(g.n1y), 32'(e.n1y));
         if (g.n2x !== e.n2x) report("second_new_vel_x", 32'(g.n2x), 32'(e.n2x));
         if (g.n2y !== e.n2y) report("second_new_vel_y", 32'(g.n2y), 32'(e.n2y));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [POS_W-1:0] req_first_pos_x = '0, req_first_pos_y = '0;
   logic signed [POS_W-1:0] req_second_pos_x = '0, req_second_pos_y = '0;
   logic signed [VEL_W-1:0] req_first_vel_x = '0, req_first_vel_y = '0;
   logic signed [VEL_W-1:0] req_second_vel_x = '0, req_second_vel_y = '0;
   logic [RAD_W-1:0]  req_first_radius = '0, req_second_radius = '0;
   logic [MASS_W-1:0] req_first_mass = 16'd1, req_second_mass = 16'd1;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_approaching, rsp_collides, rsp_degenerate, rsp_saturated;
   logic signed [VEL_W-1:0] rsp_first_new_vel_x, rsp_first_new_vel_y;
   logic signed [VEL_W-1:0] rsp_second_new_vel_x, rsp_second_new_vel_y;
   logic csr_wr_en = 1'b0;
   logic [SCALE_W-1:0] csr_wr_data = '0;

   collision_scoreboard board = new();
   int  cycle_count = 0;
   bit  steady = 1'b0;    // when set, neither side inserts idle cycles
   int  sent = 0;

   disk_pair_elastic_collision #(.POS_FRAC_BITS(POS_FRAC)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLE) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result monitor: every beat that leaves the block goes to the scoreboard.
   always @(posedge clock) begin
      outcome_type g;
      if (!reset && rsp_valid && !rsp_stall) begin
         g.appr = rsp_approaching;
         g.coll = rsp_collides;
         g.degen = rsp_degenerate;
         g.sat = rsp_saturated;
         g.n1x = rsp_first_new_vel_x;
         g.n1y = rsp_first_new_vel_y;
         g.n2x = rsp_second_new_vel_x;
         g.n2y = rsp_second_new_vel_y;
         board.check_beat(g);
      end
   end

   // Receiver back-pressure: before each beat it holds stall high for a
   // random number of cycles, then lowers it until a beat is taken.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = steady ? 0 : int'($urandom_range(0, 11));
         repeat (hold) begin
            rsp_stall <= 1'b1;
            @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Present one pair after a random gap and hold it until it is accepted.
   // The scoreboard is told of the pair at the accepting edge.
   task send_pair(pair_type p);
      int gap;
      gap = steady ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_first_pos_x <= p.x1;
      req_first_pos_y <= p.y1;
      req_first_vel_x <= p.u1;
      req_first_vel_y <= p.w1;
      req_first_radius <= p.r1;
      req_first_mass <= p.m1;
      req_second_pos_x <= p.x2;
      req_second_pos_y <= p.y2;
      req_second_vel_x <= p.u2;
      req_second_vel_y <= p.w2;
      req_second_radius <= p.r2;
      req_second_mass <= p.m2;
      do @(posedge clock); while (req_stall);
      board.note_pair(p);
      sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every predicted beat has come back, then let
   // the pipeline settle so that the next register write sees an idle block.
   task drain_pipeline();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      @(negedge clock);
   endtask

   task write_scale(logic [SCALE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.scale = value;
   endtask

   function automatic pair_type make_pair(
      longint x1, longint y1, longint u1, longint w1, int r1, int m1,
      longint x2, longint y2, longint u2, longint w2, int r2, int m2);
      pair_type p;
      p.x1 = POS_W'(x1); p.y1 = POS_W'(y1); p.u1 = VEL_W'(u1); p.w1 = VEL_W'(w1);
      p.r1 = RAD_W'(r1); p.m1 = MASS_W'(m1);
      p.x2 = POS_W'(x2); p.y2 = POS_W'(y2); p.u2 = VEL_W'(u2); p.w2 = VEL_W'(w2);
      p.r2 = RAD_W'(r2); p.m2 = MASS_W'(m2);
      return p;
   endfunction

   function automatic logic [MASS_W-1:0] pick_mass();
      logic [MASS_W-1:0] m;
      case ($urandom_range(0, 3))
         0: m = MASS_W'($urandom_range(1, 16));
         1: m = 16'hffff - MASS_W'($urandom_range(0, 15));
         default: m = MASS_W'($urandom_range(1, 65535));
      endcase
      return m;
   endfunction

   function automatic logic signed [VEL_W-1:0] pick_vel();
      return ($urandom_range(0, 2) == 0) ? VEL_W'($urandom())
                                         : VEL_W'($signed($urandom_range(0, 4095)) - 2048);
   endfunction

   // Most random pairs have each axis offset within the radius sum plus 64, so
   // that the collision arithmetic is exercised; the rest are raw noise or pairs
   // whose centres coincide.
   function automatic pair_type random_pair();
      pair_type p;
      longint reach, dx, dy;
      int kind;
      kind = int'($urandom_range(0, 19));
      p.u1 = pick_vel();
      p.w1 = pick_vel();
      p.u2 = pick_vel();
      p.w2 = pick_vel();
      p.m1 = pick_mass();
      p.m2 = pick_mass();
      if (kind < 3) begin
         p.x1 = POS_W'($urandom()); p.y1 = POS_W'($urandom());
         p.x2 = POS_W'($urandom()); p.y2 = POS_W'($urandom());
         p.r1 = RAD_W'($urandom()); p.r2 = RAD_W'($urandom());
      end else begin
         p.r1 = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 40));
         p.r2 = ($urandom_range(0, 3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 40));
         reach = ((longint'(p.r1) + longint'(p.r2)) << POS_FRAC) + 64;
         dx = (kind == 3) ? 0 : longint'($urandom_range(0, 32'(2 * reach))) - reach;
         dy = (kind == 3) ? 0 : longint'($urandom_range(0, 32'(2 * reach))) - reach;
         p.x2 = POS_W'(longint'($urandom_range(0, 8000000)) - 4000000);
         p.y2 = POS_W'(longint'($urandom_range(0, 8000000)) - 4000000);
         p.x1 = POS_W'(longint'(p.x2) + dx);
         p.y1 = POS_W'(longint'(p.y2) + dy);
      end
      return p;
   endfunction

   // Extremes, exact touching distance, coincident centres, head-on impact,
   // a separating pair, velocity saturation and eight random pairs.
   task run_directed();
      pair_type p;
      send_pair(make_pair(-8388608, -8388608, -32768, -32768, 0, 1,
                          8388607, 8388607, 32767, 32767, 1023, 65535));
      send_pair(make_pair(8388607, 8388607, -32768, -32768, 1023, 65535,
                          -8388608, -8388608, 32767, 32767, 1023, 1));
      send_pair(make_pair(1000, 2000, 256, -256, 5, 10, 1000, 2000, -256, 256, 5, 10));
      send_pair(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1));
      // Head-on impact of equal masses: the velocities swap.
      send_pair(make_pair(0, 0, 256, 0, 10, 100, 5120, 0, -256, 0, 10, 100));
      // Exactly touching, then one step too far apart.
      send_pair(make_pair(2560, 0, -256, 0, 5, 7, 0, 0, 0, 0, 5, 9));
      send_pair(make_pair(2561, 0, -256, 0, 5, 7, 0, 0, 0, 0, 5, 9));
      // Separating pair inside contact range.
      send_pair(make_pair(0, 0, -300, 0, 20, 3, 256, 0, 300, 0, 20, 3));
      // A light disk struck hard: its new velocity saturates.
      send_pair(make_pair(0, 0, 32767, 32767, 1023, 1, 256, 256, -32768, -32768, 1023, 65535));
      send_pair(make_pair(0, 0, -32768, 100, 1023, 65535, -256, 3, 32767, -100, 1023, 1));
      send_pair(make_pair(-5, 7, 1, -1, 1, 1, 3, -4, -1, 1, 0, 1));
      send_pair(make_pair(100, -100, 32767, 0, 0, 65535, -100, 100, -32768, 0, 1023, 65535));
      repeat (8) begin
         p = random_pair();
         send_pair(p);
      end
   endtask

   initial begin
      logic [SCALE_W-1:0] settings[6];
      settings[0] = SCALE_RESET;
      settings[1] = 16'h0000;
      settings[2] = 16'hffff;
      settings[3] = 16'h4000;
      settings[4] = 16'hc000;
      settings[5] = SCALE_W'($urandom());
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (int phase = 0; phase < 6; phase++) begin
         // The first phase keeps the reset value of the scale register.
         if (phase > 0) begin
            drain_pipeline();
            write_scale(settings[phase]);
         end
         steady = (phase == 2) || (phase == 4);
         for (int i = 0; i < 245; i++)
            send_pair(random_pair());
      end
      drain_pipeline();
      $display("%0d pairs sent, %0d beats checked, %0d collisions, %0d saturated",
               sent, board.checked, board.collisions, board.saturations);
      $display("six momentum scale settings covered, including 0.0 and the maximum");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
